/* hdl/lapf_pkg.sv */
// ----------------------------------------------------------------------------
// Laplacian edge filter package
// Shared widths, register indexes, operation codes and window selection codes
// for the 3x3 four-neighbour Laplacian edge filter.
// ----------------------------------------------------------------------------
package lapf_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int PIX_W        = 8;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam int LINE_SLOTS   = 3;
    localparam int SLOT_W       = 2;
    localparam int SUM_W        = PIX_W + 2;

    localparam int RESET_WIDTH  = 512;
    localparam int RESET_HEIGHT = 512;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] WIN_NORMAL       = 2'd0;
    localparam logic [1:0] WIN_LEFT_MIRROR  = 2'd1;
    localparam logic [1:0] WIN_RIGHT_MIRROR = 2'd2;

    localparam logic [PIX_W-1:0] EDGE_MAX = {PIX_W{1'b1}};

    typedef struct packed {
        logic       emit;
        logic [1:0] win_mode;
        logic       top_mirror;
        logic       bot_mirror;
        logic       last;
    } win_ctl_t;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] result;
        case (slot)
            2'd0:    result = 2'd1;
            2'd1:    result = 2'd2;
            default: result = 2'd0;
        endcase
        return result;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] result;
        case (slot)
            2'd1:    result = 2'd0;
            2'd2:    result = 2'd1;
            default: result = 2'd2;
        endcase
        return result;
    endfunction

endpackage

/* hdl/laplacian_edge_filter_3x3_top.sv */
// ----------------------------------------------------------------------------
// Laplacian edge filter, 3x3 four-neighbour
// Streams 8-bit grayscale pixels through three line memories and a 3x3
// window and returns min(255, 4*|up+down+left+right-4*centre|) per pixel.
// ----------------------------------------------------------------------------
// The filter accepts one transaction per clock while the output side is not
// stalled, and returns the result for a pixel width+1 transactions after that
// pixel, so each frame ends with width+1 drain transactions; a result passes
// through the B stage registers, the C window registers and the output
// register. The rate is set by the single write port and single read port of
// each of the three line memories of MAX_WIDTH pixels. Borders mirror without
// repeating the edge pixel. A configuration write restarts the frame.
module laplacian_edge_filter_3x3_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lapf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lapf_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lapf_pkg::PIX_W-1:0]          s_axis_tdata,  // pixel
    input  logic                                s_axis_tuser,  // operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lapf_pkg::PIX_W-1:0]          m_axis_tdata,  // edge_value
    output logic                                m_axis_tlast
);

    import lapf_pkg::*;

    logic [COL_W-1:0]  w_last_reg;
    logic [ROW_W-1:0]  h_reg;
    logic [COL_W-1:0]  w_last_next;
    logic [ROW_W-1:0]  h_next;
    logic [WIDTH_REG_W-1:0]  cfg_width;
    logic [HEIGHT_REG_W-1:0] cfg_height;

    logic [ROW_W-1:0]  feed_row_reg;
    logic [COL_W-1:0]  feed_col_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic              in_fire;
    logic              done;
    logic              step;
    logic              store;
    logic              col_zero;
    logic [ROW_W-1:0]  out_row;
    win_ctl_t          a_ctl;

    logic              b_valid_reg;
    win_ctl_t          b_ctl_reg;
    logic [PIX_W-1:0]  b_pixel_reg;
    logic [SLOT_W-1:0] b_top_slot_reg;
    logic [SLOT_W-1:0] b_mid_slot_reg;
    logic [PIX_W-1:0]  rd_data_reg [LINE_SLOTS];

    logic              c_valid_reg;
    win_ctl_t          c_ctl_reg;
    logic [PIX_W-1:0]  mid_reg [3];
    logic [PIX_W-1:0]  top1_reg;
    logic [PIX_W-1:0]  bot1_reg;
    logic [PIX_W-1:0]  top2_reg;
    logic [PIX_W-1:0]  bot2_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic              ready_d;
    logic              c_to_d;
    logic              c_advance;
    logic              ready_c;
    logic              b_advance;
    logic              ready_b;

    logic [PIX_W-1:0]  left_px;
    logic [PIX_W-1:0]  right_px;
    logic [PIX_W-1:0]  up_px;
    logic [PIX_W-1:0]  down_px;
    logic [SUM_W-1:0]  pos_sum;
    logic [SUM_W-1:0]  neg_sum;
    logic [SUM_W-1:0]  mag;
    logic [PIX_W-1:0]  edge_value;

    // Handshake chain, last stage first.
    assign ready_d   = !out_valid_reg || m_axis_tready;
    assign c_to_d    = c_valid_reg && c_ctl_reg.emit && ready_d;
    assign c_advance = c_valid_reg && (!c_ctl_reg.emit || ready_d);
    assign ready_c   = !c_valid_reg || c_advance;
    assign b_advance = b_valid_reg && ready_c;
    assign ready_b   = !b_valid_reg || b_advance;

    assign s_axis_tready = ready_b;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        cfg_width  = cfg_wr_data[WIDTH_REG_W-1:0];
        cfg_height = cfg_wr_data[HEIGHT_REG_W-1:0];
        if (cfg_width < WIDTH_REG_W'(2))
        begin
            w_last_next = COL_W'(1);
        end
        else if (cfg_width > WIDTH_REG_W'(MAX_WIDTH))
        begin
            w_last_next = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last_next = COL_W'(cfg_width - WIDTH_REG_W'(1));
        end
        if (cfg_height < HEIGHT_REG_W'(2))
        begin
            h_next = ROW_W'(2);
        end
        else if (cfg_height > HEIGHT_REG_W'(MAX_HEIGHT))
        begin
            h_next = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_next = ROW_W'(cfg_height);
        end
    end

    // Rows at and beyond the frame height are virtual rows that flush the
    // last results; the first transaction of row h_reg+1 returns to the start of the frame.
    always_comb
    begin
        in_fire  = s_axis_tvalid && s_axis_tready;
        done     = feed_row_reg >= h_reg;
        step     = in_fire && ((s_axis_tuser == OP_PIXEL) || done);
        store    = step && !done;
        col_zero = feed_col_reg == '0;
        out_row  = feed_row_reg - (col_zero ? ROW_W'(2) : ROW_W'(1));

        a_ctl.emit       = (feed_row_reg >= ROW_W'(2))
                           || ((feed_row_reg == ROW_W'(1)) && !col_zero);
        a_ctl.top_mirror = out_row == '0;
        a_ctl.bot_mirror = out_row == (h_reg - ROW_W'(1));
        a_ctl.last       = feed_row_reg == (h_reg + ROW_W'(1));
        if (col_zero)
        begin
            a_ctl.win_mode = WIN_RIGHT_MIRROR;
        end
        else if (feed_col_reg == COL_W'(1))
        begin
            a_ctl.win_mode = WIN_LEFT_MIRROR;
        end
        else
        begin
            a_ctl.win_mode = WIN_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg   <= COL_W'(RESET_WIDTH - 1);
            h_reg        <= ROW_W'(RESET_HEIGHT);
            feed_row_reg <= '0;
            feed_col_reg <= '0;
            slot_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  w_last_reg <= w_last_next;
                REG_FRAME_HEIGHT: h_reg      <= h_next;
                default:          ;
            endcase
            feed_row_reg <= '0;
            feed_col_reg <= '0;
            slot_reg     <= '0;
        end
        else if (step)
        begin
            if (a_ctl.last)
            begin
                feed_row_reg <= '0;
                feed_col_reg <= '0;
                slot_reg     <= '0;
            end
            else if (feed_col_reg == w_last_reg)
            begin
                feed_row_reg <= feed_row_reg + ROW_W'(1);
                feed_col_reg <= '0;
                slot_reg     <= slot_inc(slot_reg);
            end
            else
            begin
                feed_col_reg <= feed_col_reg + COL_W'(1);
            end
        end
    end

    for (genvar g = 0; g < LINE_SLOTS; g++)
    begin : g_line
        logic [PIX_W-1:0] line_mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (step)
            begin
                if (store && (slot_reg == SLOT_W'(g)))
                begin
                    line_mem[feed_col_reg] <= s_axis_tdata;
                end
                rd_data_reg[g] <= line_mem[feed_col_reg];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (ready_b)
        begin
            b_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            b_ctl_reg      <= a_ctl;
            b_pixel_reg    <= s_axis_tdata;
            b_top_slot_reg <= slot_inc(slot_reg);
            b_mid_slot_reg <= slot_dec(slot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (ready_c)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_advance)
        begin
            c_ctl_reg  <= b_ctl_reg;
            mid_reg[0] <= mid_reg[1];
            mid_reg[1] <= mid_reg[2];
            mid_reg[2] <= rd_data_reg[b_mid_slot_reg];
            top1_reg   <= top2_reg;
            bot1_reg   <= bot2_reg;
            top2_reg   <= rd_data_reg[b_top_slot_reg];
            bot2_reg   <= b_pixel_reg;
        end
    end

    always_comb
    begin
        case (c_ctl_reg.win_mode)
            WIN_LEFT_MIRROR:
            begin
                left_px  = mid_reg[2];
                right_px = mid_reg[2];
            end
            WIN_RIGHT_MIRROR:
            begin
                left_px  = mid_reg[0];
                right_px = mid_reg[0];
            end
            default:
            begin
                left_px  = mid_reg[0];
                right_px = mid_reg[2];
            end
        endcase
        up_px   = c_ctl_reg.top_mirror ? bot1_reg : top1_reg;
        down_px = c_ctl_reg.bot_mirror ? top1_reg : bot1_reg;
        pos_sum = SUM_W'(up_px) + SUM_W'(down_px) + SUM_W'(left_px) + SUM_W'(right_px);
        neg_sum = {mid_reg[1], 2'b00};
        mag     = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
        edge_value = (mag[SUM_W-1:PIX_W-2] != '0) ? EDGE_MAX : {mag[PIX_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready_d)
        begin
            out_valid_reg <= c_to_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_to_d)
        begin
            out_data_reg <= edge_value;
            out_last_reg <= c_ctl_reg.last;
        end
    end

`ifndef ASSERT_OFF
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        feed_col_reg <= w_last_reg)
        else $error("feed column beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        feed_row_reg <= (h_reg + ROW_W'(1)))
        else $error("feed row beyond flush rows");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && a_ctl.last) |=> (feed_row_reg == '0 && feed_col_reg == '0 && slot_reg == '0))
        else $error("frame did not restart after its last result");

    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        c_to_d |=> (m_axis_tvalid && m_axis_tdata == $past(edge_value)))
        else $error("emitted result did not reach the output register");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg != SLOT_W'(LINE_SLOTS))
        else $error("line slot out of range");
`endif

endmodule

/* test/lapf_edge_checker.sv */
// ----------------------------------------------------------------------------
// Laplacian edge filter checker
// Watches the configuration port and both streams of the filter. It keeps its
// own copy of the line stores, frame positions and frame size, works out the
// edge value that each accepted input transaction completes, if any, and
// compares each accepted output transaction with the oldest result still due.
// ----------------------------------------------------------------------------
module lapf_edge_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lapf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lapf_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [lapf_pkg::PIX_W-1:0]          s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [lapf_pkg::PIX_W-1:0]          m_axis_tdata,
    input  logic                                m_axis_tlast,
    output int                                  pending_results,
    output int                                  mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lapf_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } edge_result_t;

    edge_result_t             edge_results_due[$];
    logic [WIDTH_REG_W-1:0]   width_reg;
    logic [HEIGHT_REG_W-1:0]  height_reg;
    logic [PIX_W-1:0]         line_rows [LINE_SLOTS][MAX_WIDTH];
    int unsigned              in_col;
    int unsigned              in_row;
    int unsigned              out_col;
    int unsigned              out_row;
    bit                       frame_stored;
    int                       errors;

    assign mismatch_count = errors;

    function automatic int unsigned frame_cols();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int unsigned frame_rows();
        if (height_reg < 2) return 2;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic int pixel_at(input int unsigned r, input int unsigned c);
        return int'(line_rows[r % LINE_SLOTS][c % MAX_WIDTH]);
    endfunction

    function automatic void restart_frame();
        in_col       = 0;
        in_row       = 0;
        out_col      = 0;
        out_row      = 0;
        frame_stored = 1'b0;
    endfunction

    function automatic void filter_item(input logic op, input logic [PIX_W-1:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  received;
        int unsigned  next_out;
        int unsigned  north;
        int unsigned  south;
        int unsigned  west;
        int unsigned  east;
        int           sum;
        int           mag;
        edge_result_t res;
        w = frame_cols();
        h = frame_rows();
        if (op == OP_PIXEL && !frame_stored)
        begin
            line_rows[in_row % LINE_SLOTS][in_col % MAX_WIDTH] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row       = 0;
                    frame_stored = 1'b1;
                end
            end
        end
        received = frame_stored ? w * h : in_row * w + in_col;
        next_out = out_row * w + out_col;
        if (!frame_stored && received < next_out + w + 2) return;

        north = (out_row == 0) ? 1 : out_row - 1;
        south = (out_row + 1 >= h) ? h - 2 : out_row + 1;
        west  = (out_col == 0) ? 1 : out_col - 1;
        east  = (out_col + 1 >= w) ? w - 2 : out_col + 1;
        sum = pixel_at(north, out_col) + pixel_at(south, out_col)
            + pixel_at(out_row, west) + pixel_at(out_row, east)
            - 4 * pixel_at(out_row, out_col);
        mag = (sum < 0) ? -sum : sum;
        mag = mag * 4;
        if (mag > 255) mag = 255;
        res.edge_value = mag[PIX_W-1:0];
        res.frame_last = (out_row + 1 >= h) && (out_col + 1 >= w);
        edge_results_due.push_back(res);

        if (res.frame_last)
        begin
            restart_frame();
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        edge_result_t due;
        if (!rst_n)
        begin
            width_reg  = WIDTH_REG_W'(RESET_WIDTH);
            height_reg = HEIGHT_REG_W'(RESET_HEIGHT);
            foreach (line_rows[i, j]) line_rows[i][j] = '0;
            restart_frame();
            edge_results_due.delete();
            errors = 0;
            pending_results <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (edge_results_due.size() == 0)
                begin
                    $error("unexpected result: edge_value %0d, frame_last %0d",
                           m_axis_tdata, m_axis_tlast);
                    errors++;
                end
                else
                begin
                    due = edge_results_due.pop_front();
                    if (m_axis_tdata !== due.edge_value)
                    begin
                        $error("edge_value mismatch: expected %0d, actual %0d",
                               due.edge_value, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== due.frame_last)
                    begin
                        $error("frame_last mismatch: expected %0d, actual %0d",
                               due.frame_last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                begin
                    width_reg = cfg_wr_data[WIDTH_REG_W-1:0];
                    restart_frame();
                end
                else if (cfg_index == REG_FRAME_HEIGHT)
                begin
                    height_reg = cfg_wr_data[HEIGHT_REG_W-1:0];
                    restart_frame();
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                filter_item(s_axis_tuser, s_axis_tdata);
            pending_results <= edge_results_due.size();
        end
    end

endmodule

/* test/tb_laplacian_edge_filter_3x3_top.sv */
// ----------------------------------------------------------------------------
// Laplacian edge filter testbench
// Configures frame sizes from the smallest to the largest, including values
// that clamp, then streams directed and random frames with early drains,
// stray pixels and aborted frames. The sender runs in random bursts and the
// receiver stalls in random stretches; the checker does all comparison.
// ----------------------------------------------------------------------------
module tb_laplacian_edge_filter_3x3_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lapf_pkg::*;

    localparam int RANDOM_PIXELS  = 300;
    localparam int WIDE_PIXELS    = 1030;
    localparam int TALL_PIXELS    = 24;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        STYLE_NOISE,
        STYLE_BINARY,
        STYLE_SMOOTH,
        STYLE_FLAT
    } frame_style_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wr_data   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIX_W-1:0]       s_axis_tdata  = '0;
    logic                   s_axis_tuser  = OP_PIXEL;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [PIX_W-1:0]       m_axis_tdata;
    logic                   m_axis_tlast;
    int                     pending_results;
    int                     mismatch_count;
    int                     burst_left    = 0;
    int                     pixels_sent   = 0;
    int                     idle_cycles   = 0;
    int                     ready_run     = 0;
    int                     ready_mode    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    laplacian_edge_filter_3x3_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    lapf_edge_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    // Receiver: long stretches of full readiness alternate with random and
    // fully stalled stretches.
    always @(posedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_mode = $urandom_range(0, 9);
            ready_run  = (ready_mode < 4) ? $urandom_range(20, 120) : $urandom_range(1, 16);
        end
        ready_run--;
        if (ready_mode < 4)
            m_axis_tready <= 1'b1;
        else if (ready_mode < 8)
            m_axis_tready <= 1'($urandom_range(0, 1));
        else
            m_axis_tready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [PIX_W-1:0] px);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= px;
        do @(posedge clk); while (!s_axis_tready);
        if (op == OP_PIXEL) pixels_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [CFG_DATA_W-1:0] width_data,
                                    input logic [CFG_DATA_W-1:0] height_data);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_FRAME_WIDTH;
        cfg_wr_data <= width_data;
        @(posedge clk);
        cfg_index   <= REG_FRAME_HEIGHT;
        cfg_wr_data <= height_data;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] frame_pixel(input frame_style_t style,
                                                     input int base);
        case (style)
            STYLE_NOISE:  return PIX_W'($urandom_range(0, 255));
            STYLE_BINARY: return ($urandom_range(0, 1) != 0) ? EDGE_MAX : '0;
            STYLE_SMOOTH: return PIX_W'(base + $urandom_range(0, 15));
            default:      return PIX_W'(base);
        endcase
    endfunction

    // A plain frame is complete and clean; otherwise it may carry early drains,
    // stray pixels in its tail, or be cut short.
    task automatic run_frame(input int w, input int h, input bit plain, output bit aborted);
        frame_style_t style;
        int           base;
        int           cut;
        int           strays;
        bit           noisy;
        style  = frame_style_t'($urandom_range(0, 3));
        base   = $urandom_range(0, 240);
        noisy  = !plain && ($urandom_range(0, 9) == 0);
        cut    = (!plain && $urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
        strays = (!plain && $urandom_range(0, 6) == 0) ? $urandom_range(1, w + 1) : 0;
        aborted = (cut < w * h);
        for (int i = 0; i < cut; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(OP_DRAIN, PIX_W'($urandom_range(0, 255)));
            send_item(OP_PIXEL, frame_pixel(style, base));
        end
        if (!aborted)
            for (int i = 0; i <= w; i++)
                send_item((i < strays) ? OP_PIXEL : OP_DRAIN, PIX_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [PIX_W-1:0]      corner_pixels [12];
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        bit                    aborted;
        int                    w;
        int                    h;
        int                    stop_at;
        int                    pick;
        corner_pixels = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0,
                          8'd10, 8'd12, 8'd7, 8'd200};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Saturating sums of both signs, an early drain, and a stray pixel in
        // the tail of the frame.
        write_frame_size(13'd4, 13'd3);
        for (int i = 0; i < 12; i++)
        begin
            send_item(OP_PIXEL, corner_pixels[i]);
            if (i == 2) send_item(OP_DRAIN, 8'hFF);
        end
        send_item(OP_PIXEL, 8'hA5);
        send_item(OP_DRAIN, 8'h00);
        send_item(OP_DRAIN, 8'h5A);
        send_item(OP_DRAIN, 8'hFF);
        send_item(OP_DRAIN, 8'h81);

        // A register write in the middle of a frame restarts it; the upper
        // bits of the width value fall outside the register.
        write_frame_size(13'h1805, 13'd4);
        for (int i = 0; i < 9; i++) send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
        write_frame_size(13'h1805, 13'd4);
        run_frame(5, 4, 1'b1, aborted);

        write_frame_size(13'd0, 13'd1);
        run_frame(2, 2, 1'b1, aborted);
        write_frame_size(13'd1, 13'd0);
        run_frame(2, 2, 1'b1, aborted);

        // Frames at the largest sizes are cut short once their first results
        // are out; the next register write restarts them.
        write_frame_size(13'd2047, 13'd2);
        for (int i = 0; i < WIDE_PIXELS; i++) send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
        write_frame_size(13'd2, 13'd4096);
        for (int i = 0; i < TALL_PIXELS; i++) send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
        write_frame_size(13'd3, 13'h1FFF);
        for (int i = 0; i < TALL_PIXELS; i++) send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));

        stop_at = pixels_sent + RANDOM_PIXELS;
        aborted = 1'b1;
        while (pixels_sent < stop_at)
        begin
            if (aborted || $urandom_range(0, 9) < 6)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                    w = $urandom_range(2, 12);
                else if (pick < 19)
                    w = $urandom_range(13, 48);
                else
                    w = $urandom_range(49, 96);
                if (w > 48)
                    h = 2;
                else
                    h = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
                w_data = CFG_DATA_W'(w);
                h_data = CFG_DATA_W'(h);
                if (w == 2 && $urandom_range(0, 2) == 0)
                    w_data = CFG_DATA_W'($urandom_range(0, 1));
                else if ($urandom_range(0, 4) == 0)
                    w_data = w_data | 13'h1800;
                if (h == 2 && $urandom_range(0, 2) == 0)
                    h_data = CFG_DATA_W'($urandom_range(0, 1));
                write_frame_size(w_data, h_data);
            end
            run_frame(w, h, 1'b0, aborted);
        end

        settle();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lapf_pkg.sv
hdl/laplacian_edge_filter_3x3_top.sv
test/lapf_edge_checker.sv
test/tb_laplacian_edge_filter_3x3_top.sv
